[hdl/bis_pkg.sv]
package bis_pkg;

	localparam int DIM_W       = 8;
	localparam int CHAN_W      = 3;
	localparam int STRIDE_W    = DIM_W + CHAN_W;
	localparam int COORD_W     = 17;
	localparam int POS_W       = COORD_W - 1;
	localparam int ROW_W       = DIM_W + STRIDE_W;
	localparam int COL_W       = DIM_W + CHAN_W;
	localparam int SUM_W       = ROW_W + 1;
	localparam int VALUE_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_ZERO   = 2'd2
	} op_kind_t;

	typedef struct packed {
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [CHAN_W-1:0]   channels;
		logic [STRIDE_W-1:0] stride;
	} geom_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [DIM_W-1:0]   x1;
		logic [DIM_W-1:0]   x2;
		logic [DIM_W-1:0]   y1;
		logic [DIM_W-1:0]   y2;
		logic [POS_W-1:0]   fx;
		logic [POS_W-1:0]   fy;
		logic [CHAN_W-1:0]  chan;
		logic [VALUE_W-1:0] value;
	} op_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic idle;
		logic emit;
	} back_status_t;

endpackage

[hdl/bis_req_if.sv]
interface bis_req_if
	import bis_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;
	logic [CHAN_W-1:0]         channel_select;
	logic [VALUE_W-1:0]        write_value;

	modport source (output valid, output command, output x_coord, output y_coord,
		output channel_select, output write_value, input ready);
	modport sink (input valid, input command, input x_coord, input y_coord,
		input channel_select, input write_value, output ready);
endinterface

[hdl/bis_rsp_if.sv]
interface bis_rsp_if
	import bis_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink (input valid, input sample_value, output ready);
endinterface

[hdl/bis_cfg_if.sv]
interface bis_cfg_if
	import bis_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/bis_front.sv]
module bis_front
	import bis_pkg::*;
#(
	parameter int FRACTION_BITS = 8
) (
	bis_req_if.sink req,
	input  geom_t   geom,
	input  logic    push_ready,
	output logic    push_valid,
	output op_t     push_op
);

	typedef struct packed {
		logic [DIM_W-1:0] pos;
		logic [DIM_W-1:0] nxt;
		logic [POS_W-1:0] frac;
	} axis_t;

	localparam logic [POS_W-1:0] FRAC_MASK = POS_W'((32'd1 << FRACTION_BITS) - 32'd1);

	// clamp to 0..last in whole pixels; at or past the last pixel the fraction drops
	function automatic axis_t clamp_axis(input logic signed [COORD_W-1:0] coord,
		input logic [DIM_W-1:0] last);
		logic [POS_W-1:0] mag;
		logic             over;
		axis_t            a;
		mag  = POS_W'(coord[POS_W-1:0] >> FRACTION_BITS);
		over = mag >= POS_W'(last);
		if (coord[COORD_W-1]) begin
			a.pos  = '0;
			a.frac = '0;
		end else if (over) begin
			a.pos  = last;
			a.frac = '0;
		end else begin
			a.pos  = mag[DIM_W-1:0];
			a.frac = coord[POS_W-1:0] & FRAC_MASK;
		end
		a.nxt = (a.pos == last) ? a.pos : a.pos + DIM_W'(1);
		return a;
	endfunction

	axis_t ax;
	axis_t ay;
	logic  bad_chan;

	always_comb begin
		ax       = clamp_axis(req.x_coord, geom.width - DIM_W'(1));
		ay       = clamp_axis(req.y_coord, geom.height - DIM_W'(1));
		bad_chan = req.channel_select >= geom.channels;

		push_op.x1    = ax.pos;
		push_op.x2    = ax.nxt;
		push_op.y1    = ay.pos;
		push_op.y2    = ay.nxt;
		push_op.fx    = ax.frac;
		push_op.fy    = ay.frac;
		push_op.chan  = req.channel_select;
		push_op.value = req.write_value;
		if (req.command == CMD_SAMPLE) begin
			push_op.kind = bad_chan ? OP_ZERO : OP_SAMPLE;
		end else begin
			push_op.kind = OP_WRITE;
		end

		// a write to a missing channel is taken and dropped here
		push_valid = req.valid && !(req.command == CMD_WRITE && bad_chan);
		req.ready  = push_ready;
	end

endmodule

[hdl/bis_queue.sv]
module bis_queue
	import bis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  op_t       push_op,
	output logic      push_ready,
	input  logic      pop,
	output op_t       pop_op,
	output q_status_t stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	always_comb begin
		stat.empty = count_q == '0;
		stat.full  = count_q == CNT_W'(QUEUE_DEPTH);
		push_ready = !stat.full;
		push       = push_valid && push_ready;
		pop_op     = entry_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

[hdl/bis_back.sv]
module bis_back
	import bis_pkg::*;
#(
	parameter int MAX_WIDTH     = 128,
	parameter int MAX_HEIGHT    = 128,
	parameter int MAX_CHANNELS  = 4,
	parameter int FRACTION_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  geom_t        geom,
	input  q_status_t    q_stat,
	input  op_t          q_op,
	output logic         pop,
	output back_status_t stat,
	bis_rsp_if.source    rsp
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int EXT_W  = (ADDR_W > SUM_W) ? ADDR_W : SUM_W;
	localparam int ONE_W  = FRACTION_BITS + 1;
	localparam int WGT_W  = 2 * FRACTION_BITS + 1;
	localparam int ACC_W  = 2 * FRACTION_BITS + VALUE_W;
	localparam int PROD_W = WGT_W + VALUE_W;

	localparam logic [ONE_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SETUP = 6'b000010,
		ST_WRITE = 6'b000100,
		ST_READ  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [ROW_W-1:0]   row1_q;
	logic [ROW_W-1:0]   row2_q;
	logic [COL_W-1:0]   col1_q;
	logic [COL_W-1:0]   col2_q;
	logic [WGT_W-1:0]   wgt_q [4];
	logic [1:0]         k_q;
	logic [ACC_W-1:0]   acc_q;
	logic [VALUE_W-1:0] res_q;
	logic               res_valid_q;

	logic               v_s1;
	logic [1:0]         sel_s1;
	logic [VALUE_W-1:0] rdata_s1;
	logic               v_s2;
	logic [PROD_W-1:0]  prod_s2;

	logic [VALUE_W-1:0] mem [DEPTH];

	logic [FRACTION_BITS-1:0] fx;
	logic [FRACTION_BITS-1:0] fy;
	logic [ONE_W-1:0]         gx;
	logic [ONE_W-1:0]         gy;
	logic [EXT_W-1:0]         addr_sum;
	logic [ADDR_W-1:0]        addr;
	logic                     mem_we;
	logic                     mem_re;
	logic                     emit_fire;

	always_comb begin
		fx = op_q.fx[FRACTION_BITS-1:0];
		fy = op_q.fy[FRACTION_BITS-1:0];
		gx = ONE - ONE_W'(fx);
		gy = ONE - ONE_W'(fy);

		// neighbour order: (x1,y1) (x2,y1) (x1,y2) (x2,y2)
		addr_sum = EXT_W'(k_q[1] ? row2_q : row1_q) + EXT_W'(k_q[0] ? col2_q : col1_q);
		addr     = addr_sum[ADDR_W-1:0];

		pop       = (state_q == ST_IDLE) && !q_stat.empty;
		mem_we    = state_q == ST_WRITE;
		mem_re    = state_q == ST_READ;
		emit_fire = (state_q == ST_EMIT) && (!res_valid_q || rsp.ready);

		stat.idle = state_q == ST_IDLE;
		stat.emit = state_q == ST_EMIT;

		rsp.valid        = res_valid_q;
		rsp.sample_value = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1 <= mem_re;
			v_s2 <= v_s1;
			if (emit_fire) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						k_q <= '0;
						case (q_op.kind)
							OP_ZERO: state_q <= ST_EMIT;
							default: state_q <= ST_SETUP;
						endcase
					end
				end
				ST_SETUP: begin
					state_q <= (op_q.kind == OP_WRITE) ? ST_WRITE : ST_READ;
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for the last product to land in the accumulator
					if (!v_s1 && !v_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q  <= q_op;
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2[ACC_W-1:0];
		end
		if (state_q == ST_SETUP) begin
			row1_q   <= ROW_W'(op_q.y1) * ROW_W'(geom.stride);
			row2_q   <= ROW_W'(op_q.y2) * ROW_W'(geom.stride);
			col1_q   <= COL_W'(op_q.x1) * COL_W'(geom.channels) + COL_W'(op_q.chan);
			col2_q   <= COL_W'(op_q.x2) * COL_W'(geom.channels) + COL_W'(op_q.chan);
			wgt_q[0] <= WGT_W'(gx) * WGT_W'(gy);
			wgt_q[1] <= WGT_W'(fx) * WGT_W'(gy);
			wgt_q[2] <= WGT_W'(gx) * WGT_W'(fy);
			wgt_q[3] <= WGT_W'(fx) * WGT_W'(fy);
		end
		sel_s1  <= k_q;
		prod_s2 <= PROD_W'(rdata_s1) * PROD_W'(wgt_q[sel_s1]);
		if (emit_fire) begin
			res_q <= acc_q[ACC_W-1 -: VALUE_W];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= op_q.value;
		end
		if (mem_re) begin
			rdata_s1 <= mem[addr];
		end
	end

endmodule

[hdl/bilinear_image_sampler.sv]
// Bilinear sampler over an interleaved 8-bit image held in one single-port memory of
// MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS bytes, with no reset and no clearing pass: a sample
// must only touch pixels that were written. The request side takes a word in any cycle
// that the two-entry queue has room, so with the engine idle up to three requests go in
// back to back (two queued, one picked up by the engine straight away).
// The engine behind the queue steps a write through dequeue, address and store, and a
// sample through dequeue, address and weights, four neighbour reads on the one memory
// port, a multiply-accumulate drain and the load of the result register, which waits
// while the last result is not taken; a missing-channel sample goes from dequeue to
// that load. The engine, the bottleneck, takes no new word until done with the last.
// Geometry registers must be written only while the block is idle; it does not check.
module bilinear_image_sampler
	import bis_pkg::*;
#(
	parameter int MAX_WIDTH     = 128,
	parameter int MAX_HEIGHT    = 128,
	parameter int MAX_CHANNELS  = 4,
	parameter int FRACTION_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	bis_req_if.sink    req,
	bis_rsp_if.source  rsp,
	bis_cfg_if.sink    cfg
);

	localparam logic [DIM_W-1:0]    RST_WIDTH    = DIM_W'((MAX_WIDTH < 128) ? MAX_WIDTH : 128);
	localparam logic [DIM_W-1:0]    RST_HEIGHT   = DIM_W'((MAX_HEIGHT < 128) ? MAX_HEIGHT : 128);
	localparam logic [CHAN_W-1:0]   RST_CHANNELS = CHAN_W'((MAX_CHANNELS < 4) ? MAX_CHANNELS : 4);
	localparam logic [STRIDE_W-1:0] RST_STRIDE   = STRIDE_W'(RST_WIDTH) * STRIDE_W'(RST_CHANNELS);

	// zero acts as one, anything past the store's limit as the limit
	function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v, input int maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > maxv) begin
			r = DIM_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] limit_chan(input logic [CHAN_W-1:0] v);
		logic [CHAN_W-1:0] r;
		if (v == '0) begin
			r = CHAN_W'(1);
		end else if (32'(v) > MAX_CHANNELS) begin
			r = CHAN_W'(MAX_CHANNELS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [CHAN_W-1:0]   channels_q;
	logic [STRIDE_W-1:0] stride_q;
	geom_t               geom;

	logic         push_valid;
	logic         push_ready;
	op_t          push_op;
	op_t          q_op;
	logic         q_pop;
	q_status_t    q_stat;
	back_status_t back_stat;

	assign cfg.ready = 1'b1;

	always_comb begin
		geom.width    = width_q;
		geom.height   = height_q;
		geom.channels = channels_q;
		geom.stride   = stride_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RST_WIDTH;
			height_q   <= RST_HEIGHT;
			channels_q <= RST_CHANNELS;
			stride_q   <= RST_STRIDE;
		end else begin
			// row pitch in bytes, registered from the width and channel count registers
			stride_q <= STRIDE_W'(width_q) * STRIDE_W'(channels_q);
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_WIDTH:    width_q    <= limit_dim(cfg.data, MAX_WIDTH);
					REG_HEIGHT:   height_q   <= limit_dim(cfg.data, MAX_HEIGHT);
					REG_CHANNELS: channels_q <= limit_chan(cfg.data[CHAN_W-1:0]);
					default: begin
					end
				endcase
			end
		end
	end

	bis_front #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.req        (req),
		.geom       (geom),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_op    (push_op)
	);

	bis_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop        (q_pop),
		.pop_op     (q_op),
		.stat       (q_stat)
	);

	bis_back #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HEIGHT    (MAX_HEIGHT),
		.MAX_CHANNELS  (MAX_CHANNELS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.geom   (geom),
		.q_stat (q_stat),
		.q_op   (q_op),
		.pop    (q_pop),
		.stat   (back_stat),
		.rsp    (rsp)
	);

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_ready |=> !q_stat.empty)
		else $error("queued word missing after push");

	a_idle_picks_up: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty && back_stat.idle |=> !back_stat.idle)
		else $error("engine left a queued word waiting");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.emit && (!rsp.valid || rsp.ready) |=> rsp.valid)
		else $error("finished sample not presented");

endmodule

[verif/tb.sv]
module tb;
	import bis_pkg::*;

	localparam int FRAC_BITS    = 8;
	localparam int FRAC_ONE     = 1 << FRAC_BITS;
	localparam int MAX_DIM      = 128;
	localparam int MAX_CHANS    = 4;
	localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM * MAX_CHANS;
	localparam int RANDOM_ITEMS = 1750;
	localparam int PHASE_COUNT  = 14;
	localparam int PHASE_ITEMS  = RANDOM_ITEMS / PHASE_COUNT;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 16;
	localparam int N_DIRECTED   = 23;
	localparam int N_PLANNED    = 11;

	typedef struct packed {
		logic               command;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [CHAN_W-1:0]  chan;
		logic [VALUE_W-1:0] value;
		logic               known;
		logic [VALUE_W-1:0] known_value;
	} pixel_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bis_req_if req_bus ();
	bis_rsp_if rsp_bus ();
	bis_cfg_if cfg_bus ();

	bilinear_image_sampler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the block: raw geometry registers and the pixel memory
	logic [DIM_W-1:0]   geom_w = 8'd128;
	logic [DIM_W-1:0]   geom_h = 8'd128;
	logic [CHAN_W-1:0]  geom_c = 3'd4;
	logic [VALUE_W-1:0] pixel_mem [STORE_DEPTH];
	bit                 pixel_written [STORE_DEPTH];

	logic [VALUE_W-1:0] pending_samples [$];
	int fail_count = 0;
	int items_sent = 0;
	int idle_mode  = 1;
	bit hold_request = 1'b0;

	// directed stimulus: corner patches, clamping at both ends, invalid channels
	pixel_cmd_t directed_rows [N_DIRECTED] = '{
		{CMD_WRITE,  17'h10000, 17'h10000, 3'd0, 8'hFF, 1'b0, 8'h00},
		{CMD_WRITE,  17'h001FF, 17'h00000, 3'd0, 8'hFF, 1'b0, 8'h00},
		{CMD_WRITE,  17'h1FFFF, 17'h00100, 3'd0, 8'hFF, 1'b0, 8'h00},
		{CMD_WRITE,  17'h00180, 17'h001C0, 3'd0, 8'hFF, 1'b0, 8'h00},
		{CMD_SAMPLE, 17'h00080, 17'h000FF, 3'd0, 8'h00, 1'b1, 8'hFF},
		{CMD_SAMPLE, 17'h10000, 17'h10000, 3'd0, 8'h3C, 1'b1, 8'hFF},
		{CMD_WRITE,  17'h00000, 17'h00000, 3'd1, 8'h00, 1'b0, 8'h00},
		{CMD_WRITE,  17'h00100, 17'h00000, 3'd1, 8'h00, 1'b0, 8'h00},
		{CMD_WRITE,  17'h00000, 17'h00100, 3'd1, 8'h00, 1'b0, 8'h00},
		{CMD_WRITE,  17'h00100, 17'h00100, 3'd1, 8'h00, 1'b0, 8'h00},
		{CMD_SAMPLE, 17'h000C0, 17'h00040, 3'd1, 8'h00, 1'b1, 8'h00},
		{CMD_WRITE,  17'h00000, 17'h00000, 3'd2, 8'h10, 1'b0, 8'h00},
		{CMD_WRITE,  17'h00100, 17'h00000, 3'd2, 8'h80, 1'b0, 8'h00},
		{CMD_WRITE,  17'h00000, 17'h00100, 3'd2, 8'hC0, 1'b0, 8'h00},
		{CMD_WRITE,  17'h00100, 17'h00100, 3'd2, 8'h33, 1'b0, 8'h00},
		{CMD_SAMPLE, 17'h00040, 17'h000C0, 3'd2, 8'h00, 1'b0, 8'h00},
		{CMD_WRITE,  17'h0FFFF, 17'h0FFFF, 3'd3, 8'hA5, 1'b0, 8'h00},
		{CMD_SAMPLE, 17'h0FFFF, 17'h0FFFF, 3'd3, 8'h00, 1'b1, 8'hA5},
		{CMD_WRITE,  17'h00000, 17'h00000, 3'd4, 8'h5A, 1'b0, 8'h00},
		{CMD_WRITE,  17'h00100, 17'h00000, 3'd7, 8'h00, 1'b0, 8'h00},
		{CMD_SAMPLE, 17'h00000, 17'h00000, 3'd4, 8'h00, 1'b1, 8'h00},
		{CMD_SAMPLE, 17'h1FFFF, 17'h00000, 3'd7, 8'h00, 1'b1, 8'h00},
		// channel 4 write above would have landed on pixel (1,0) channel 0
		{CMD_SAMPLE, 17'h00080, 17'h00000, 3'd0, 8'h00, 1'b1, 8'hFF}
	};

	// width, height, channel count as raw register bytes
	logic [23:0] geometry_plan [N_PLANNED] = '{
		{8'd1,   8'd1,   8'd1},
		{8'd0,   8'd0,   8'd0},
		{8'd255, 8'd255, 8'hFF},
		{8'd128, 8'd1,   8'd3},
		{8'd1,   8'd128, 8'd2},
		{8'd2,   8'd2,   8'd4},
		{8'd5,   8'd3,   8'd3},
		{8'd9,   8'd17,  8'd1},
		{8'd200, 8'd6,   8'hFD},
		{8'd3,   8'd128, 8'h0A},
		{8'd128, 8'd128, 8'd4}
	};

	function automatic int limit_dim(int v, int maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic int eff_width();
		return limit_dim(int'(geom_w), MAX_DIM);
	endfunction

	function automatic int eff_height();
		return limit_dim(int'(geom_h), MAX_DIM);
	endfunction

	function automatic int eff_chans();
		return limit_dim(int'(geom_c), MAX_CHANS);
	endfunction

	function automatic int pixel_index(int x, int y, int c);
		return ((y * eff_width() + x) * eff_chans() + c) % STORE_DEPTH;
	endfunction

	// clamp a sample coordinate into the image, then split into neighbours and weight
	function automatic void clamp_axis(input logic signed [COORD_W-1:0] coord, input int size,
			output int near, output int far, output int frac);
		int lim;
		int v;
		lim = (size - 1) * FRAC_ONE;
		v = coord;
		if (v < 0)
			v = 0;
		if (v > lim)
			v = lim;
		near = v >> FRAC_BITS;
		frac = v & (FRAC_ONE - 1);
		far = (near + 1 < size) ? near + 1 : size - 1;
	endfunction

	function automatic void apply_command(input pixel_cmd_t item, output bit produces,
			output logic [VALUE_W-1:0] result);
		int w, h, ch;
		int xa, xb, ya, yb, fx, fy;
		int acc;
		w = eff_width();
		h = eff_height();
		ch = eff_chans();
		produces = 1'b0;
		result = '0;
		if (item.command == CMD_WRITE) begin
			if (int'(item.chan) < ch) begin
				xa = $signed(item.x_coord) >>> FRAC_BITS;
				ya = $signed(item.y_coord) >>> FRAC_BITS;
				xa = (xa < 0) ? 0 : (xa > w - 1) ? w - 1 : xa;
				ya = (ya < 0) ? 0 : (ya > h - 1) ? h - 1 : ya;
				pixel_mem[pixel_index(xa, ya, item.chan)] = item.value;
				pixel_written[pixel_index(xa, ya, item.chan)] = 1'b1;
			end
		end else begin
			produces = 1'b1;
			if (int'(item.chan) < ch) begin
				clamp_axis(item.x_coord, w, xa, xb, fx);
				clamp_axis(item.y_coord, h, ya, yb, fy);
				acc = int'(pixel_mem[pixel_index(xa, ya, item.chan)]) * (FRAC_ONE - fx) * (FRAC_ONE - fy)
					+ int'(pixel_mem[pixel_index(xb, ya, item.chan)]) * fx * (FRAC_ONE - fy)
					+ int'(pixel_mem[pixel_index(xa, yb, item.chan)]) * (FRAC_ONE - fx) * fy
					+ int'(pixel_mem[pixel_index(xb, yb, item.chan)]) * fx * fy;
				result = 8'(acc >> (2 * FRAC_BITS));
			end
		end
	endfunction

	function automatic int pick_gap(int mode);
		int r;
		if (mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < ((mode == 1) ? 60 : 30))
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// often inside a small window so that samples reuse pixels, some off the edges
	function automatic logic [COORD_W-1:0] rand_coord(int size);
		int r, ip, fr;
		r = $urandom_range(0, 99);
		fr = $urandom_range(0, FRAC_ONE - 1);
		if ($urandom_range(0, 4) == 0)
			fr = 0;
		if (r < 40)
			ip = $urandom_range(0, ((size < 12) ? size : 12) - 1);
		else if (r < 60)
			ip = $urandom_range(0, size - 1);
		else if (r < 72)
			ip = size - 1 + int'($urandom_range(0, 2));
		else if (r < 80)
			ip = 0 - int'($urandom_range(1, 3));
		else if (r < 90)
			return 17'($urandom);
		else begin
			case ($urandom_range(0, 3))
				0: return 17'h10000;
				1: return 17'h0FFFF;
				2: return 17'h00000;
				default: return 17'h1FFFF;
			endcase
		end
		return 17'(ip * FRAC_ONE + fr);
	endfunction

	task automatic send_item(pixel_cmd_t item);
		int gap;
		bit produces;
		logic [VALUE_W-1:0] predicted;
		gap = pick_gap(idle_mode);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid          <= 1'b1;
		req_bus.command        <= item.command;
		req_bus.x_coord        <= item.x_coord;
		req_bus.y_coord        <= item.y_coord;
		req_bus.channel_select <= item.chan;
		req_bus.write_value    <= item.value;
		@(posedge clk);
		while (req_bus.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
		apply_command(item, produces, predicted);
		if (produces)
			pending_samples.push_back(item.known ? item.known_value : predicted);
	endtask

	task automatic send_write(int x, int y, int c, int frac_x, int frac_y);
		pixel_cmd_t item;
		item = '0;
		item.command = CMD_WRITE;
		item.x_coord = 17'(x * FRAC_ONE + frac_x);
		item.y_coord = 17'(y * FRAC_ONE + frac_y);
		item.chan = 3'(c);
		item.value = 8'($urandom);
		send_item(item);
	endtask

	task automatic fill_pixel(int x, int y, int c);
		if (!pixel_written[pixel_index(x, y, c)])
			send_write(x, y, c, $urandom_range(0, FRAC_ONE - 1), $urandom_range(0, FRAC_ONE - 1));
	endtask

	// a sample preceded by writes to any of its four neighbours not yet stored
	task automatic send_sample(int c);
		pixel_cmd_t item;
		int xa, xb, ya, yb, fx, fy;
		item = '0;
		item.command = CMD_SAMPLE;
		item.x_coord = rand_coord(eff_width());
		item.y_coord = rand_coord(eff_height());
		item.chan = 3'(c);
		item.value = 8'($urandom);
		if (c < eff_chans()) begin
			clamp_axis(item.x_coord, eff_width(), xa, xb, fx);
			clamp_axis(item.y_coord, eff_height(), ya, yb, fy);
			fill_pixel(xa, ya, c);
			fill_pixel(xb, ya, c);
			fill_pixel(xa, yb, c);
			fill_pixel(xb, yb, c);
		end
		send_item(item);
	endtask

	task automatic send_random();
		pixel_cmd_t item;
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			send_sample($urandom_range(0, eff_chans() - 1));
		else if (r < 70)
			send_sample($urandom_range(0, 7));
		else begin
			item = '0;
			item.command = CMD_WRITE;
			item.x_coord = rand_coord(eff_width());
			item.y_coord = rand_coord(eff_height());
			item.chan = (r < 95) ? 3'($urandom_range(0, eff_chans() - 1)) : 3'($urandom_range(0, 7));
			item.value = 8'($urandom);
			send_item(item);
		end
	endtask

	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		// trailing writes leave no result behind, give them time to retire
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_geometry(logic [23:0] geom);
		cfg_reg_t regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		regs = '{REG_WIDTH, REG_HEIGHT, REG_CHANNELS};
		vals = '{geom[23:16], geom[15:8], geom[7:0]};
		cfg_bus.valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_bus.index <= regs[i];
			cfg_bus.data  <= vals[i];
			@(posedge clk);
			while (cfg_bus.ready !== 1'b1)
				@(posedge clk);
			case (regs[i])
				REG_WIDTH:    geom_w = vals[i];
				REG_HEIGHT:   geom_h = vals[i];
				REG_CHANNELS: geom_c = vals[i][CHAN_W-1:0];
				default: ;
			endcase
		end
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic run_phase(bit with_hold);
		int first;
		int mode_left;
		first = items_sent;
		mode_left = 0;
		if (with_hold) begin
			// block fills up behind a stalled receiver while words keep coming
			hold_request = 1'b1;
			idle_mode = 0;
			mode_left = 40;
		end
		while (items_sent - first < PHASE_ITEMS) begin
			if (mode_left == 0) begin
				idle_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 60);
			end
			mode_left--;
			send_random();
			if ($urandom_range(0, 199) == 0)
				wait_idle();
		end
	endtask

	initial begin : stimulus
		logic [23:0] geom;
		req_bus.valid          <= 1'b0;
		req_bus.command        <= CMD_WRITE;
		req_bus.x_coord        <= '0;
		req_bus.y_coord        <= '0;
		req_bus.channel_select <= '0;
		req_bus.write_value    <= '0;
		cfg_bus.valid          <= 1'b0;
		cfg_bus.index          <= REG_WIDTH;
		cfg_bus.data           <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_item(directed_rows[i]);
		run_phase(1'b1);

		for (int p = 1; p < PHASE_COUNT; p++) begin
			wait_idle();
			if (p <= N_PLANNED)
				geom = geometry_plan[p - 1];
			else
				geom = {8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
					8'($urandom_range(1, 4))};
			program_geometry(geom);
			run_phase(p == 4);
		end

		req_bus.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_samples.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin : result_checker
		int stall;
		logic [VALUE_W-1:0] want;
		stall = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
				if (pending_samples.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected sample word: got %0d", rsp_bus.sample_value);
				end else begin
					want = pending_samples.pop_front();
					if (rsp_bus.sample_value !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("sample_value mismatch: expected %0d, got %0d",
								want, rsp_bus.sample_value);
					end
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				stall--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
				stall = pick_gap(idle_mode);
			end
		end
	end

	initial begin : watchdog
		#24_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

[bilinear_image_sampler.f]
hdl/bis_pkg.sv
hdl/bis_req_if.sv
hdl/bis_rsp_if.sv
hdl/bis_cfg_if.sv
hdl/bis_front.sv
hdl/bis_queue.sv
hdl/bis_back.sv
hdl/bilinear_image_sampler.sv
verif/tb.sv
